[hw/rtl/mbde_pkg.sv]
// ----------------------------------------------------------------------------
// mbde_pkg: shared types and constants of the distance estimator
// Fixed-point constants (28 fraction bits), CORDIC step tables, sequencer
// states and the request structs between the top level and its units.
// ----------------------------------------------------------------------------
package mbde_pkg;

  localparam int ANG_W            = 40;
  localparam int CORDIC_STEPS_DEF = 32;
  localparam int DIV_STEPS        = 80;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam logic signed [63:0] ONE_Q     = 64'sd268435456;
  localparam logic signed [63:0] BAILOUT_Q = 64'sd536870912;
  localparam logic signed [63:0] INV_K_Q   = 64'sd163008218;
  localparam logic [63:0]        DR_MAX_Q  = 64'h3FFF_FFFF_FFFF_FFFF;

  localparam ang_t PI_Q      = 40'sd843314857;
  localparam ang_t HALF_PI_Q = 40'sd421657428;
  localparam ang_t TWO_PI_Q  = 40'sd1686629713;
  localparam ang_t LN2_Q     = 40'sd186065280;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 1'd1;
  localparam logic [4:0]  POWER_DEF  = 5'd8;
  localparam logic [15:0] MAX_IT_DEF = 16'd10000;

  typedef enum logic [1:0] {CM_VEC, CM_ROT, CM_HYP} cor_mode_t;

  typedef struct packed {
    logic      start;
    cor_mode_t mode;
  } cor_req_t;

  typedef struct packed {
    logic start;
    logic sgn;
  } mul_req_t;

  typedef enum logic [2:0] {CJ_PHI, CJ_THETA, CJ_SINT, CJ_SINP, CJ_LN} cjob_t;

  typedef enum logic [3:0] {
    OP_RHO, OP_R, OP_RP, OP_ZR, OP_DR, OP_T1, OP_ZX, OP_T2, OP_ZY, OP_ZZ, OP_MAG
  } mop_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ITER, S_PHI, S_THETA, S_BAIL, S_POW, S_RED_MUL, S_RED, S_FOLD1,
    S_FOLD2, S_COR_GO, S_COR_WAIT, S_MUL_GO, S_MUL_WAIT, S_FIN, S_LN_MSB,
    S_LN_NORM, S_DIV, S_DIV_END, S_OUT
  } state_t;

  // Circular CORDIC step angle atan(2^-i)
  function automatic ang_t atan_step(int unsigned i);
    ang_t v;
    v = '0;
    unique case (i)
      0: v = 40'sd210828714;
      1: v = 40'sd124459457;
      2: v = 40'sd65760959;
      3: v = 40'sd33381289;
      4: v = 40'sd16755421;
      5: v = 40'sd8385878;
      6: v = 40'sd4193962;
      7: v = 40'sd2097109;
      8: v = 40'sd1048570;
      default: begin
        if (i <= 28) v = ang_t'(40'sd1 <<< (28 - i)) - 40'sd1;
        else v = '0;
      end
    endcase
    return v;
  endfunction

  // Hyperbolic CORDIC step angle atanh(2^-i)
  function automatic ang_t atanh_step(int unsigned i);
    ang_t v;
    v = '0;
    unique case (i)
      1: v = 40'sd147453245;
      2: v = 40'sd68561854;
      3: v = 40'sd33730851;
      4: v = 40'sd16799112;
      5: v = 40'sd8391340;
      6: v = 40'sd4194645;
      7: v = 40'sd2097194;
      8: v = 40'sd1048581;
      default: begin
        if (i >= 9 && i <= 28) v = ang_t'(40'sd1 <<< (28 - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/mbde_mul.sv]
// ----------------------------------------------------------------------------
// mbde_mul: shared 64x64 fixed-point multiplier
// One 32x32 partial product per cycle into an accumulator, then truncate to 28
// fraction bits with saturation; optional sign-magnitude handling.
// ----------------------------------------------------------------------------
module mbde_mul (
  input  logic              clk,
  input  logic              rst,
  input  mbde_pkg::mul_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic [63:0]       p,
  output logic              done
);

  logic [63:0]  ua, ub;
  logic         neg, sgn, busy, fin;
  logic [1:0]   cnt;
  logic [127:0] acc;
  logic [31:0]  a_h, b_h;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [63:0]  u, p_next;
  logic         ovf;

  // Select halves and form the partial product
  always_comb begin
    a_h = cnt[0] ? ua[63:32] : ua[31:0];
    b_h = cnt[1] ? ub[63:32] : ub[31:0];
    pp  = a_h * b_h;
    sh  = {cnt[0] & cnt[1], cnt[0] ^ cnt[1], 5'd0};
  end

  // Truncate, saturate and restore sign
  always_comb begin
    ovf = |acc[127:92];
    u   = ovf ? '1 : acc[91:28];
    if (sgn && u[63]) u = 64'h7FFF_FFFF_FFFF_FFFF;
    p_next = neg ? (64'd0 - u) : u;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      ua  <= (req.sgn && a[63]) ? (64'd0 - a) : a;
      ub  <= (req.sgn && b[63]) ? (64'd0 - b) : b;
      neg <= req.sgn && (a[63] ^ b[63]);
      sgn <= req.sgn;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + ({64'd0, pp} << sh);
    end
    if (fin) p <= p_next;
  end

endmodule

[hw/rtl/mbde_cordic.sv]
// ----------------------------------------------------------------------------
// mbde_cordic: shared CORDIC engine, one micro-rotation per cycle
// Circular vectoring, circular rotation and hyperbolic vectoring on 64-bit
// x/y with a narrow angle accumulator.
// ----------------------------------------------------------------------------
module mbde_cordic #(
  parameter int CORDIC_STEPS = mbde_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mbde_pkg::cor_req_t req,
  input  logic signed [63:0] x0,
  input  logic signed [63:0] y0,
  input  mbde_pkg::ang_t     z0,
  output logic signed [63:0] x,
  output logic signed [63:0] y,
  output mbde_pkg::ang_t     z,
  output logic               done
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);
  localparam logic [IW-1:0] LAST_C = IW'(CORDIC_STEPS - 1);
  localparam logic [IW-1:0] LAST_H = IW'(CORDIC_STEPS);

  mbde_pkg::cor_mode_t mode;
  logic [IW-1:0]       i;
  logic                rep, busy, dir, rpt, last;
  logic signed [63:0]  dx, dy, x_n, y_n;
  mbde_pkg::ang_t      at, ath, z_n;

  // One micro-rotation
  always_comb begin
    dx  = y >>> i;
    dy  = x >>> i;
    at  = mbde_pkg::atan_step(int'(i));
    ath = mbde_pkg::atanh_step(int'(i));
    unique case (mode)
      mbde_pkg::CM_VEC: begin
        dir = (y > 64'sd0);
        x_n = dir ? x + dx : x - dx;
        y_n = dir ? y - dy : y + dy;
        z_n = dir ? z + at : z - at;
      end
      mbde_pkg::CM_ROT: begin
        dir = (z >= 0);
        x_n = dir ? x - dx : x + dx;
        y_n = dir ? y + dy : y - dy;
        z_n = dir ? z - at : z + at;
      end
      default: begin
        dir = (y >= 64'sd0);
        x_n = dir ? x - dx : x + dx;
        y_n = dir ? y - dy : y + dy;
        z_n = dir ? z + ath : z - ath;
      end
    endcase
    rpt  = (mode == mbde_pkg::CM_HYP) && !rep &&
           (int'(i) == 4 || int'(i) == 13 || int'(i) == 40);
    last = (mode == mbde_pkg::CM_HYP) ? (i == LAST_H && !rpt) : (i == LAST_C);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rep  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rep  <= 1'b0;
      end else if (busy) begin
        rep <= rpt;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath; vectoring folds a negative x into the right half plane
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      i    <= (req.mode == mbde_pkg::CM_HYP) ? IW'(1) : '0;
      if (req.mode == mbde_pkg::CM_VEC && x0 < 64'sd0) begin
        x <= 64'sd0 - x0;
        y <= 64'sd0 - y0;
        z <= (y0 >= 64'sd0) ? mbde_pkg::PI_Q : -mbde_pkg::PI_Q;
      end else begin
        x <= x0;
        y <= y0;
        z <= (req.mode == mbde_pkg::CM_VEC) ? '0 : z0;
      end
    end else if (busy) begin
      x <= x_n;
      y <= y_n;
      z <= z_n;
      if (!rpt) i <= i + IW'(1);
    end
  end

endmodule

[hw/rtl/mandelbulb_distance_estimator_top.sv]
// Per iteration each angle passes the angle reduction loop; at exit with a positive r
//   a leading-one search, a hyperbolic log and an 80-step divide follow.
// Throughput: one point at a time; the shared CORDIC engine and the shared
//   multiplier set the per-iteration cost.
// Reset: rst (synchronous, active high) clears the sequencer and output valid and
//   sets power to 8 and max_iterations to 10000; no clearing pass.
// ----------------------------------------------------------------------------
// mandelbulb_distance_estimator_top: Mandelbulb distance estimate, power n
// Sequencer around one CORDIC engine, one multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module mandelbulb_distance_estimator_top #(
  parameter int CORDIC_STEPS = mbde_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mbde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             point_x,
  input  logic signed [31:0]             point_y,
  input  logic signed [31:0]             point_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             distance
);

  localparam int AW = mbde_pkg::ANG_W;

  mbde_pkg::state_t state, state_next;
  mbde_pkg::cjob_t  cjob;
  mbde_pkg::mop_t   mop;

  logic [4:0]  power_reg, n, k;
  logic [15:0] max_it_reg, it;

  logic signed [63:0] px, py, pz, zx, zy, zz, rho, r, st, ct, sp, cp, t;
  logic [63:0]        rp, zr, dr;
  mbde_pkg::ang_t     phi, theta, red_a, lnr;
  logic               red_sel, sc_neg;
  logic [5:0]         ln_b;
  logic signed [6:0]  ln_e;
  logic [79:0]        dvd;
  logic [63:0]        rem;
  logic [31:0]        quo;
  logic               ovf;
  logic [6:0]         div_cnt;
  logic signed [31:0] result;

  mbde_pkg::cor_mode_t cor_mode;
  logic signed [63:0]  cor_x0, cor_y0, cor_x, cor_y;
  mbde_pkg::ang_t      cor_z0, cor_z;
  logic                cor_done, mul_done;
  mbde_pkg::cor_req_t  cor_req;
  mbde_pkg::mul_req_t  mul_req;
  logic [63:0]         mul_a, mul_b, mul_p;

  // Combinational helpers
  logic [68:0]        rpn_full;
  logic signed [45:0] red_prod;
  logic               red_done, ln_found, out_free;
  mbde_pkg::ang_t     f1_a, f2_a, lnr_new, lnr_abs;
  logic               f2_neg;
  logic [63:0]        dr_c, dr_p1, ln_m, rem_sh;
  logic               div_ge;

  mbde_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .p    (mul_p),
    .done (mul_done)
  );

  mbde_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (cor_req),
    .x0   (cor_x0),
    .y0   (cor_y0),
    .z0   (cor_z0),
    .x    (cor_x),
    .y    (cor_y),
    .z    (cor_z),
    .done (cor_done)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_reg  <= mbde_pkg::POWER_DEF;
      max_it_reg <= mbde_pkg::MAX_IT_DEF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbde_pkg::REG_POWER:    power_reg  <= cfg_data[4:0];
        mbde_pkg::REG_MAX_ITER: max_it_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Helper logic
  always_comb begin
    rpn_full = rp * n;
    red_prod = (red_sel ? phi : theta) * $signed({1'b0, n});
    red_done = red_a[AW-1] ? (red_a > -mbde_pkg::TWO_PI_Q)
                           : (red_a < mbde_pkg::TWO_PI_Q);
    if (red_a > mbde_pkg::PI_Q)       f1_a = red_a - mbde_pkg::TWO_PI_Q;
    else if (red_a < -mbde_pkg::PI_Q) f1_a = red_a + mbde_pkg::TWO_PI_Q;
    else                              f1_a = red_a;
    if (red_a > mbde_pkg::HALF_PI_Q) begin
      f2_a = red_a - mbde_pkg::PI_Q;
      f2_neg = 1'b1;
    end else if (red_a < -mbde_pkg::HALF_PI_Q) begin
      f2_a = red_a + mbde_pkg::PI_Q;
      f2_neg = 1'b1;
    end else begin
      f2_a = red_a;
      f2_neg = 1'b0;
    end
    dr_c  = (mul_p > mbde_pkg::DR_MAX_Q) ? mbde_pkg::DR_MAX_Q : mul_p;
    dr_p1 = dr_c + 64'(mbde_pkg::ONE_Q);
    if (dr_p1 > mbde_pkg::DR_MAX_Q) dr_p1 = mbde_pkg::DR_MAX_Q;
    ln_found = r[ln_b] || (ln_b == 6'd0);
    ln_m = (ln_b >= 6'd28) ? (64'(r) >> (ln_b - 6'd28)) : (64'(r) << (6'd28 - ln_b));
    lnr_new = mbde_pkg::ang_t'(ln_e * mbde_pkg::LN2_Q) + (cor_z <<< 1);
    lnr_abs = lnr[AW-1] ? -lnr : lnr;
    rem_sh  = {rem[62:0], dvd[79]};
    div_ge  = (rem_sh >= dr);
    out_free = !out_valid || !out_stall;
  end

  // Multiplier request and operand select
  always_comb begin
    mul_req.start = (state == mbde_pkg::S_MUL_GO);
    mul_a = 64'(rp);
    mul_b = 64'(r);
    mul_req.sgn = 1'b1;
    unique case (mop)
      mbde_pkg::OP_RHO, mbde_pkg::OP_R: begin
        mul_a = cor_x;
        mul_b = mbde_pkg::INV_K_Q;
      end
      mbde_pkg::OP_RP, mbde_pkg::OP_ZR: begin
        mul_req.sgn = 1'b0;
      end
      mbde_pkg::OP_DR: begin
        mul_a = rpn_full[63:0];
        mul_b = dr;
        mul_req.sgn = 1'b0;
      end
      mbde_pkg::OP_T1: begin
        mul_a = st;
        mul_b = cp;
      end
      mbde_pkg::OP_T2: begin
        mul_a = sp;
        mul_b = st;
      end
      mbde_pkg::OP_ZX, mbde_pkg::OP_ZY: begin
        mul_a = zr;
        mul_b = t;
      end
      mbde_pkg::OP_ZZ: begin
        mul_a = zr;
        mul_b = ct;
      end
      mbde_pkg::OP_MAG: begin
        mul_a = {{(64-AW){1'b0}}, lnr_abs};
        mul_b = r;
        mul_req.sgn = 1'b0;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mbde_pkg::S_IDLE:    if (in_valid) state_next = mbde_pkg::S_ITER;
      mbde_pkg::S_ITER:    state_next = (it == max_it_reg) ? mbde_pkg::S_FIN
                                                           : mbde_pkg::S_PHI;
      mbde_pkg::S_PHI:     state_next = (zx != 64'sd0 || zy != 64'sd0) ?
                                        mbde_pkg::S_COR_GO : mbde_pkg::S_THETA;
      mbde_pkg::S_THETA:   state_next = (rho == 64'sd0 && zz == 64'sd0) ?
                                        mbde_pkg::S_BAIL : mbde_pkg::S_COR_GO;
      mbde_pkg::S_BAIL:    state_next = (r > mbde_pkg::BAILOUT_Q) ? mbde_pkg::S_FIN
                                                                  : mbde_pkg::S_POW;
      mbde_pkg::S_POW:     state_next = mbde_pkg::S_MUL_GO;
      mbde_pkg::S_RED_MUL: state_next = mbde_pkg::S_RED;
      mbde_pkg::S_RED:     if (red_done) state_next = mbde_pkg::S_FOLD1;
      mbde_pkg::S_FOLD1:   state_next = mbde_pkg::S_FOLD2;
      mbde_pkg::S_FOLD2:   state_next = mbde_pkg::S_COR_GO;
      mbde_pkg::S_COR_GO:  state_next = mbde_pkg::S_COR_WAIT;
      mbde_pkg::S_COR_WAIT: begin
        if (cor_done) begin
          priority case (cjob)
            mbde_pkg::CJ_SINT: state_next = mbde_pkg::S_RED_MUL;
            default:           state_next = mbde_pkg::S_MUL_GO;
          endcase
        end
      end
      mbde_pkg::S_MUL_GO:  state_next = mbde_pkg::S_MUL_WAIT;
      mbde_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mop)
            mbde_pkg::OP_RHO: state_next = mbde_pkg::S_THETA;
            mbde_pkg::OP_R:   state_next = mbde_pkg::S_BAIL;
            mbde_pkg::OP_RP:  state_next = mbde_pkg::S_POW;
            mbde_pkg::OP_DR:  state_next = mbde_pkg::S_RED_MUL;
            mbde_pkg::OP_ZZ:  state_next = mbde_pkg::S_ITER;
            mbde_pkg::OP_MAG: state_next = mbde_pkg::S_DIV;
            default:          state_next = mbde_pkg::S_MUL_GO;
          endcase
        end
      end
      mbde_pkg::S_FIN:     state_next = (r <= 64'sd0) ? mbde_pkg::S_OUT
                                                      : mbde_pkg::S_LN_MSB;
      mbde_pkg::S_LN_MSB:  if (ln_found) state_next = mbde_pkg::S_LN_NORM;
      mbde_pkg::S_LN_NORM: state_next = mbde_pkg::S_COR_GO;
      mbde_pkg::S_DIV:     if (div_cnt == 7'(mbde_pkg::DIV_STEPS - 1))
                             state_next = mbde_pkg::S_DIV_END;
      mbde_pkg::S_DIV_END: state_next = mbde_pkg::S_OUT;
      mbde_pkg::S_OUT:     if (out_free) state_next = mbde_pkg::S_IDLE;
      default:             state_next = mbde_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall      = (state != mbde_pkg::S_IDLE);
    cor_req.start = (state == mbde_pkg::S_COR_GO);
    cor_req.mode  = cor_mode;
  end

  // State register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbde_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mbde_pkg::S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)         out_valid <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mbde_pkg::S_IDLE: begin
        px <= {{20{point_x[31]}}, point_x, 12'd0};
        py <= {{20{point_y[31]}}, point_y, 12'd0};
        pz <= {{20{point_z[31]}}, point_z, 12'd0};
        zx <= {{20{point_x[31]}}, point_x, 12'd0};
        zy <= {{20{point_y[31]}}, point_y, 12'd0};
        zz <= {{20{point_z[31]}}, point_z, 12'd0};
        r  <= '0;
        dr <= 64'(mbde_pkg::ONE_Q);
        it <= '0;
        n  <= (power_reg < 5'd2) ? 5'd2 : ((power_reg > 5'd16) ? 5'd16 : power_reg);
      end
      mbde_pkg::S_PHI: begin
        rho <= '0;
        phi <= '0;
        cor_mode <= mbde_pkg::CM_VEC;
        cor_x0 <= zx;
        cor_y0 <= zy;
        cor_z0 <= '0;
        cjob <= mbde_pkg::CJ_PHI;
      end
      mbde_pkg::S_THETA: begin
        r     <= '0;
        theta <= '0;
        cor_mode <= mbde_pkg::CM_VEC;
        cor_x0 <= zz;
        cor_y0 <= rho;
        cor_z0 <= '0;
        cjob <= mbde_pkg::CJ_THETA;
      end
      mbde_pkg::S_BAIL: begin
        rp <= 64'(mbde_pkg::ONE_Q);
        k  <= 5'd1;
      end
      mbde_pkg::S_POW: mop <= (k < n) ? mbde_pkg::OP_RP : mbde_pkg::OP_ZR;
      mbde_pkg::S_RED_MUL: red_a <= mbde_pkg::ang_t'(red_prod[AW-1:0]);
      mbde_pkg::S_RED: begin
        if (!red_done) begin
          red_a <= red_a[AW-1] ? red_a + mbde_pkg::TWO_PI_Q
                               : red_a - mbde_pkg::TWO_PI_Q;
        end
      end
      mbde_pkg::S_FOLD1: red_a <= f1_a;
      mbde_pkg::S_FOLD2: begin
        sc_neg <= f2_neg;
        cor_mode <= mbde_pkg::CM_ROT;
        cor_x0 <= mbde_pkg::INV_K_Q;
        cor_y0 <= '0;
        cor_z0 <= f2_a;
        cjob <= red_sel ? mbde_pkg::CJ_SINP : mbde_pkg::CJ_SINT;
      end
      mbde_pkg::S_COR_WAIT: begin
        if (cor_done) begin
          unique case (cjob)
            mbde_pkg::CJ_PHI: begin
              phi <= cor_z;
              mop <= mbde_pkg::OP_RHO;
            end
            mbde_pkg::CJ_THETA: begin
              theta <= cor_z;
              mop <= mbde_pkg::OP_R;
            end
            mbde_pkg::CJ_SINT: begin
              st <= sc_neg ? -cor_y : cor_y;
              ct <= sc_neg ? -cor_x : cor_x;
              red_sel <= 1'b1;
            end
            mbde_pkg::CJ_SINP: begin
              sp <= sc_neg ? -cor_y : cor_y;
              cp <= sc_neg ? -cor_x : cor_x;
              mop <= mbde_pkg::OP_T1;
            end
            default: begin
              lnr <= lnr_new;
              mop <= mbde_pkg::OP_MAG;
            end
          endcase
        end
      end
      mbde_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mop)
            mbde_pkg::OP_RHO: rho <= mul_p;
            mbde_pkg::OP_R:   r <= mul_p;
            mbde_pkg::OP_RP: begin
              rp <= mul_p;
              k  <= k + 5'd1;
            end
            mbde_pkg::OP_ZR: begin
              zr  <= mul_p;
              mop <= mbde_pkg::OP_DR;
            end
            mbde_pkg::OP_DR: begin
              dr <= dr_p1;
              red_sel <= 1'b0;
            end
            mbde_pkg::OP_T1: begin
              t   <= mul_p;
              mop <= mbde_pkg::OP_ZX;
            end
            mbde_pkg::OP_ZX: begin
              zx  <= mul_p + px;
              mop <= mbde_pkg::OP_T2;
            end
            mbde_pkg::OP_T2: begin
              t   <= mul_p;
              mop <= mbde_pkg::OP_ZY;
            end
            mbde_pkg::OP_ZY: begin
              zy  <= mul_p + py;
              mop <= mbde_pkg::OP_ZZ;
            end
            mbde_pkg::OP_ZZ: begin
              zz <= mul_p + pz;
              it <= it + 16'd1;
            end
            default: begin
              dvd     <= {1'b0, mul_p[63:1], 16'd0};
              rem     <= '0;
              quo     <= '0;
              ovf     <= 1'b0;
              div_cnt <= '0;
            end
          endcase
        end
      end
      mbde_pkg::S_FIN: begin
        result <= '0;
        ln_b   <= 6'd63;
      end
      mbde_pkg::S_LN_MSB: if (!ln_found) ln_b <= ln_b - 6'd1;
      mbde_pkg::S_LN_NORM: begin
        ln_e <= $signed({1'b0, ln_b}) - 7'sd28;
        cor_mode <= mbde_pkg::CM_HYP;
        cor_x0 <= ln_m + mbde_pkg::ONE_Q;
        cor_y0 <= ln_m - mbde_pkg::ONE_Q;
        cor_z0 <= '0;
        cjob <= mbde_pkg::CJ_LN;
      end
      mbde_pkg::S_DIV: begin
        rem     <= div_ge ? rem_sh - dr : rem_sh;
        quo     <= {quo[30:0], div_ge};
        ovf     <= ovf | quo[31];
        dvd     <= {dvd[78:0], 1'b0};
        div_cnt <= div_cnt + 7'd1;
      end
      mbde_pkg::S_DIV_END: begin
        if (ovf || quo[31]) result <= lnr[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else                result <= lnr[AW-1] ? -$signed(quo) : $signed(quo);
      end
      mbde_pkg::S_OUT: if (out_free) distance <= result;
      default: ;
    endcase
  end

endmodule

[bench/tb_mandelbulb_distance_estimator_top.sv]
// ----------------------------------------------------------------------------
// tb_mandelbulb_distance_estimator_top: self-checking bench of the estimator
// Drives points with bursty valid and a patterned result stall, predicts each
// distance with a bit-exact fixed-point model of the fractal iteration and
// compares every transfer on the result side in order.
// ----------------------------------------------------------------------------
module tb_mandelbulb_distance_estimator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FQ_ONE   = 64'sd268435456;
  localparam longint FQ_PI    = 64'sd843314857;
  localparam longint FQ_HPI   = 64'sd421657428;
  localparam longint FQ_2PI   = 64'sd1686629713;
  localparam longint FQ_INVK  = 64'sd163008218;
  localparam longint FQ_LN2   = 64'sd186065280;
  localparam bit [63:0] DR_SAT = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int     NSTEPS   = 32;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [mbde_pkg::CFG_IDX_W-1:0] cfg_index = mbde_pkg::REG_POWER;
  logic [15:0]                    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [31:0]             point_x = '0;
  logic signed [31:0]             point_y = '0;
  logic signed [31:0]             point_z = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [31:0]             distance;

  // Configuration mirror and expected distances
  logic [4:0]         power_cfg = mbde_pkg::POWER_DEF;
  logic [15:0]        iter_limit = mbde_pkg::MAX_IT_DEF;
  logic signed [31:0] pending_dist[$];
  int                 fail_count = 0;
  int                 burst_left = 4;
  int                 stall_tick = 0;

  mandelbulb_distance_estimator_top u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit [63:0] q_umul(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:92] != 0) return '1;
    return p[91:28];
  endfunction

  function automatic longint q_smul(longint a, longint b);
    bit        neg;
    bit [63:0] ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? 64'd0 - 64'(a) : 64'(a);
    ub = b < 0 ? 64'd0 - 64'(b) : 64'(b);
    p = q_umul(ua, ub);
    if (p > 64'h7FFF_FFFF_FFFF_FFFF) p = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint circ_angle(int unsigned i);
    case (i)
      0: return 210828714;
      1: return 124459457;
      2: return 65760959;
      3: return 33381289;
      4: return 16755421;
      5: return 8385878;
      6: return 4193962;
      7: return 2097109;
      8: return 1048570;
      default: return (i <= 28) ? (64'sd1 <<< (28 - i)) - 1 : 0;
    endcase
  endfunction

  function automatic longint hyp_angle(int unsigned i);
    case (i)
      1: return 147453245;
      2: return 68561854;
      3: return 33730851;
      4: return 16799112;
      5: return 8391340;
      6: return 4194645;
      7: return 2097194;
      8: return 1048581;
      default: return (i >= 9 && i <= 28) ? (64'sd1 <<< (28 - i)) : 0;
    endcase
  endfunction

  // Angle of (x, y) by vectoring; magnitude comes back gain-corrected
  function automatic longint polar_angle(longint x, longint y, output longint mag);
    longint ang, dx, dy;
    ang = 0;
    if (x < 0) begin
      ang = y >= 0 ? FQ_PI : -FQ_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += circ_angle(i);
      end else begin
        x -= dx; y += dy; ang -= circ_angle(i);
      end
    end
    mag = q_smul(x, FQ_INVK);
    return ang;
  endfunction

  task automatic sin_cos(longint a, output longint s, output longint c);
    longint x, y, dx, dy;
    bit     neg;
    x = FQ_INVK;
    y = 0;
    neg = 0;
    a = a % FQ_2PI;
    if (a > FQ_PI) a -= FQ_2PI;
    if (a < -FQ_PI) a += FQ_2PI;
    if (a > FQ_HPI) begin
      a -= FQ_PI; neg = 1;
    end else if (a < -FQ_HPI) begin
      a += FQ_PI; neg = 1;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= circ_angle(i);
      end else begin
        x += dx; y -= dy; a += circ_angle(i);
      end
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endtask

  function automatic longint natural_log(bit [63:0] r);
    int        b, e, reps;
    bit [63:0] m;
    longint    x, y, z, dx, dy;
    b = 63;
    z = 0;
    while (b > 0 && r[b] == 1'b0) b--;
    e = b - 28;
    m = e >= 0 ? r >> e : r << (28 - b);
    x = longint'(m) + FQ_ONE;
    y = longint'(m) - FQ_ONE;
    for (int i = 1; i <= NSTEPS; i++) begin
      reps = (i == 4 || i == 13 || i == 40) ? 2 : 1;
      for (int k = 0; k < reps; k++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x -= dx; y -= dy; z += hyp_angle(i);
        end else begin
          x += dx; y += dy; z -= hyp_angle(i);
        end
      end
    end
    return longint'(e) * FQ_LN2 + 2 * z;
  endfunction

  // Iterate the power map from c and form 0.5*ln(r)*r/dr
  task automatic predict_distance(input logic signed [31:0] cx, cy, cz,
                                  output logic signed [31:0] est);
    longint      px, py, pz, zx, zy, zz, r, rho, phi, theta, st, ct, sp, cp;
    longint      lnr, res;
    bit [63:0]   dr, rp, zr, mag, quo, rem, frac;
    int unsigned n;
    px = longint'(cx) * 4096;
    py = longint'(cy) * 4096;
    pz = longint'(cz) * 4096;
    zx = px; zy = py; zz = pz;
    r = 0;
    dr = 64'(FQ_ONE);
    n = power_cfg < 2 ? 2 : (power_cfg > 16 ? 16 : power_cfg);
    for (int it = 0; it < iter_limit; it++) begin
      rho = 0; phi = 0; theta = 0;
      rp = 64'(FQ_ONE);
      if (zx != 0 || zy != 0) phi = polar_angle(zx, zy, rho);
      if (rho == 0 && zz == 0) r = 0;
      else theta = polar_angle(zz, rho, r);
      if (r > 2 * FQ_ONE) break;
      for (int k = 1; k < n; k++) rp = q_umul(rp, 64'(r));
      zr = q_umul(rp, 64'(r));
      dr = q_umul(rp * 64'(n), dr);
      if (dr > DR_SAT) dr = DR_SAT;
      dr += 64'(FQ_ONE);
      if (dr > DR_SAT) dr = DR_SAT;
      sin_cos(theta * longint'(n), st, ct);
      sin_cos(phi * longint'(n), sp, cp);
      zx = q_smul(longint'(zr), q_smul(st, cp)) + px;
      zy = q_smul(longint'(zr), q_smul(sp, st)) + py;
      zz = q_smul(longint'(zr), ct) + pz;
    end
    if (r <= 0) begin
      res = 0;
    end else begin
      lnr = natural_log(64'(r));
      mag = q_umul(lnr < 0 ? 64'(-lnr) : 64'(lnr), 64'(r)) >> 1;
      quo = mag / dr;
      rem = mag % dr;
      frac = 0;
      if (quo >= 32768) begin
        res = lnr < 0 ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
        for (int k = 0; k < 16; k++) begin
          rem = rem << 1;
          frac = frac << 1;
          if (rem >= dr) begin
            rem -= dr; frac[0] = 1'b1;
          end
        end
        res = longint'((quo << 16) | frac);
        if (lnr < 0) res = -res;
      end
    end
    est = res[31:0];
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_dist.size() == 0) begin
        $error("distance transfer with nothing expected: actual %0d", distance);
        fail_count++;
      end else begin
        logic signed [31:0] want;
        want = pending_dist.pop_front();
        if (distance !== want) begin
          $error("distance: expected %0d actual %0d", want, distance);
          fail_count++;
        end
      end
    end
  end

  // Result stall: quiet stretches alternate with random stalling
  always @(posedge clk) begin
    stall_tick++;
    if ((stall_tick % 1500) < 500) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) != 0);
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_point(logic signed [31:0] x, y, z);
    logic signed [31:0] want;
    predict_distance(x, y, z, want);
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (in_stall);
    pending_dist.push_back(want);
    burst_left--;
    // End the burst and hold off for a random gap
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [mbde_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == mbde_pkg::REG_POWER) power_cfg = val[4:0];
    else iter_limit = val;
  endtask

  function automatic logic signed [31:0] pick_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 196608)) - 32'sd98304;
  endfunction

  // Far points bail at once, so reset defaults and the top limit stay cheap
  task automatic test_defaults;
    send_point(32'sd196608, 0, 0);
    send_point(0, -32'sd262144, 32'sd65536);
    write_reg(mbde_pkg::REG_MAX_ITER, 16'hFFFF);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
  endtask

  task automatic test_special_points;
    write_reg(mbde_pkg::REG_MAX_ITER, 16'd6);
    write_reg(mbde_pkg::REG_POWER, 16'd2);
    send_point(0, 0, 0);
    send_point(0, 0, 32'sd32768);
    send_point(0, 0, -32'sd32768);
    send_point(32'sd32768, 32'sd32768, 32'sd32768);
    send_point(-32'sd16384, 32'sd8192, -32'sd4096);
    send_point(32'sd1, -32'sd1, 32'sd1);
    send_point(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
  endtask

  task automatic test_iteration_limits;
    write_reg(mbde_pkg::REG_MAX_ITER, 16'd0);
    send_point(32'sd32768, 0, 0);
    write_reg(mbde_pkg::REG_MAX_ITER, 16'd1);
    send_point(32'sd32768, -32'sd16384, 32'sd8192);
    send_point(32'sd1000, 0, 0);
  endtask

  task automatic test_power_extremes;
    logic [4:0] pw[6] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd8};
    write_reg(mbde_pkg::REG_MAX_ITER, 16'd4);
    foreach (pw[i]) begin
      write_reg(mbde_pkg::REG_POWER, 16'(pw[i]));
      send_point(32'sd40000, -32'sd20000, 32'sd30000);
    end
  endtask

  task automatic test_random_phases;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(mbde_pkg::REG_POWER,
                ph == 0 ? 16'd2 : (ph == 1 ? 16'd16 : 16'($urandom_range(0, 31))));
      write_reg(mbde_pkg::REG_MAX_ITER, 16'($urandom_range(1, 8)));
      for (int k = 0; k < 50; k++) send_point(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_special_points();
    test_iteration_limits();
    test_power_extremes();
    test_random_phases();
    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
